// ----- rtl/rmfrf_pkg.sv -----
package rmfrf_pkg;

  // Panel geometry (landscape). Logical view is portrait.
  localparam int PANEL_WIDTH  = 800;
  localparam int PANEL_HEIGHT = 480;
  localparam int ROW_BYTES    = 100;

  localparam int STORE_DEPTH = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths fixed by the interface.
  localparam int IN_COORD_W = 11;
  localparam int BYTE_ADDR_W = 16;
  localparam int DATA_W      = 8;

  // Signed working width for clipping: holds sums of two fields and the
  // panel extents.
  localparam int COORD_W = 13;

  localparam int X_W   = $clog2(PANEL_HEIGHT);
  localparam int ROW_W = $clog2(PANEL_HEIGHT + 1);
  localparam int COL_W = $clog2((PANEL_WIDTH + 7) / 8 + 1);

  localparam logic signed [COORD_W-1:0] PH_S = COORD_W'(PANEL_HEIGHT);
  localparam logic signed [COORD_W-1:0] PW_S = COORD_W'(PANEL_WIDTH);
  localparam logic signed [COORD_W-1:0] RB_S = COORD_W'(ROW_BYTES);

  localparam logic [DATA_W-1:0] BYTE_WHITE = '1;
  localparam logic [2:0]        BIT_LAST   = 3'd7;

  localparam logic OP_FILL = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_BASE,
    ST_RUN,
    ST_DRAIN,
    ST_RDWAIT
  } state_t;

  // Clipped fill window, in bytes per panel row.
  typedef struct packed {
    logic             empty;
    logic [X_W-1:0]   x0;
    logic [ROW_W-1:0] rows;
    logic [COL_W-1:0] col0;
    logic [COL_W-1:0] col1;
    logic [2:0]       lo;
    logic [2:0]       hi;
  } clip_t;

endpackage

// ----- rtl/rmfrf_ram.sv -----
module rmfrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/rmfrf_clip.sv -----
module rmfrf_clip (
  input  logic signed [rmfrf_pkg::IN_COORD_W-1:0] left,
  input  logic signed [rmfrf_pkg::IN_COORD_W-1:0] top,
  input  logic signed [rmfrf_pkg::IN_COORD_W-1:0] span_x,
  input  logic signed [rmfrf_pkg::IN_COORD_W-1:0] span_y,
  output rmfrf_pkg::clip_t                        clip
);

  localparam int CW = rmfrf_pkg::COORD_W;

  logic signed [CW-1:0] xs, ws, xe, x0, x1;
  logic signed [CW-1:0] ys, hs, ye, y0, y1, ylast;
  logic signed [CW-1:0] col0_s, coll_s, rows_s;
  logic                 col_beyond;

  always_comb begin
    xs = CW'(left);
    ws = CW'(span_x);
    ys = CW'(top);
    hs = CW'(span_y);
    xe = xs + ws;
    ye = ys + hs;
    x0 = (xs < 0) ? '0 : xs;
    y0 = (ys < 0) ? '0 : ys;
    x1 = (xe > rmfrf_pkg::PH_S) ? rmfrf_pkg::PH_S : xe;
    y1 = (ye > rmfrf_pkg::PW_S) ? rmfrf_pkg::PW_S : ye;
    ylast  = y1 - CW'(1);
    rows_s = x1 - x0;
    col0_s = y0 >>> 3;
    coll_s = ylast >>> 3;
    // Guard for a last byte column past the row end: it is clamped to the row's last byte.
    col_beyond = (coll_s >= rmfrf_pkg::RB_S);

    clip.empty = (ws <= 0) || (hs <= 0) || (x1 <= x0) || (y1 <= y0) ||
                 (col0_s >= rmfrf_pkg::RB_S);
    clip.x0    = x0[rmfrf_pkg::X_W-1:0];
    clip.rows  = rows_s[rmfrf_pkg::ROW_W-1:0];
    clip.col0  = col0_s[rmfrf_pkg::COL_W-1:0];
    clip.col1  = col_beyond ? rmfrf_pkg::COL_W'(rmfrf_pkg::ROW_BYTES - 1)
                            : coll_s[rmfrf_pkg::COL_W-1:0];
    clip.lo    = y0[2:0];
    clip.hi    = col_beyond ? rmfrf_pkg::BIT_LAST : ylast[2:0];
  end

endmodule

// ----- rtl/rotated_mono_framebuffer_rect_fill.sv -----
// Read transaction: RAM read on accept, result registered in ST_RDWAIT once the output is free, then idle again.
// Fill transaction: SETUP, BASE, then RUN over all bytes touched (rows x byte columns), then DRAIN, then ready.
//   One byte read-modify-write per cycle through the frame RAM (1 read + 1 write port).
//   Empty or fully clipped fill: SETUP returns straight to idle. One transaction in flight at a time.
// Reset (rst_n low, synchronous): control cleared, then a clearing pass writes white to
//   every frame byte, with in_stall held high.
module rotated_mono_framebuffer_rect_fill (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_operation,
  input  logic signed [rmfrf_pkg::IN_COORD_W-1:0]  in_left,
  input  logic signed [rmfrf_pkg::IN_COORD_W-1:0]  in_top,
  input  logic signed [rmfrf_pkg::IN_COORD_W-1:0]  in_span_x,
  input  logic signed [rmfrf_pkg::IN_COORD_W-1:0]  in_span_y,
  input  logic                                     in_ink_black,
  input  logic [rmfrf_pkg::BYTE_ADDR_W-1:0]        in_byte_address,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [rmfrf_pkg::DATA_W-1:0]             out_read_data,
  output logic [rmfrf_pkg::BYTE_ADDR_W-1:0]        out_read_address
);

  localparam int AW = rmfrf_pkg::ADDR_W;
  localparam int DW = rmfrf_pkg::DATA_W;

  rmfrf_pkg::state_t state_r, state_nxt;

  // Captured fill command.
  logic signed [rmfrf_pkg::IN_COORD_W-1:0] f_left_r, f_top_r, f_span_x_r, f_span_y_r;
  logic                                    f_ink_r;

  // Clipped window and walk counters.
  rmfrf_pkg::clip_t       clip_c, clip_r;
  logic [AW-1:0]          row_base_r, row_base_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic [rmfrf_pkg::COL_W-1:0] col_r, col_nxt;
  logic [rmfrf_pkg::ROW_W-1:0] rows_r, rows_nxt;
  logic [AW-1:0]          base_c;
  logic [rmfrf_pkg::X_W-1:0] py_c;

  // Write-back stage of the read-modify-write.
  logic                   wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]          wr_addr_r;
  logic [DW-1:0]          wr_mask_r, mask_c;
  logic [2:0]             lo_sel, hi_sel;

  // Clearing pass.
  logic [AW-1:0]          clr_addr_r;

  // Read path.
  logic                   rd_oor_r;
  logic [rmfrf_pkg::BYTE_ADDR_W-1:0] rd_echo_r;
  logic                   out_valid_r;
  logic [DW-1:0]          out_data_r;
  logic [rmfrf_pkg::BYTE_ADDR_W-1:0] out_addr_r;

  // RAM ports.
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [DW-1:0]          ram_wdata, ram_rdata;

  logic in_acc, out_free, load_out, run_last_col, run_last_row, clr_done;

  rmfrf_clip u_clip (
    .left   (f_left_r),
    .top    (f_top_r),
    .span_x (f_span_x_r),
    .span_y (f_span_y_r),
    .clip   (clip_c)
  );

  rmfrf_ram #(
    .WIDTH (DW),
    .DEPTH (rmfrf_pkg::STORE_DEPTH)
  ) u_frame (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_stall = (state_r != rmfrf_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == rmfrf_pkg::ST_RDWAIT) && out_free;

  assign run_last_col = (col_r == clip_r.col1);
  assign run_last_row = (rows_r == rmfrf_pkg::ROW_W'(1));
  assign clr_done     = (clr_addr_r == AW'(rmfrf_pkg::STORE_DEPTH - 1));

  // Panel row of the first logical column; row base = py * ROW_BYTES + col0.
  assign py_c   = rmfrf_pkg::X_W'(rmfrf_pkg::PANEL_HEIGHT - 1) - clip_r.x0;
  assign base_c = AW'(32'(py_c) * 32'(rmfrf_pkg::ROW_BYTES)) + AW'(clip_r.col0);

  // Byte mask: first and last byte of a row may be partial, MSB = leftmost pixel.
  assign lo_sel = (col_r == clip_r.col0) ? clip_r.lo : 3'd0;
  assign hi_sel = run_last_col ? clip_r.hi : rmfrf_pkg::BIT_LAST;
  assign mask_c = (rmfrf_pkg::BYTE_WHITE >> lo_sel) &
                  (rmfrf_pkg::BYTE_WHITE << (rmfrf_pkg::BIT_LAST - hi_sel));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmfrf_pkg::ST_CLEAR: begin
        if (clr_done) state_nxt = rmfrf_pkg::ST_IDLE;
      end
      rmfrf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_operation == rmfrf_pkg::OP_READ) ? rmfrf_pkg::ST_RDWAIT
                                                           : rmfrf_pkg::ST_SETUP;
        end
      end
      rmfrf_pkg::ST_SETUP: begin
        state_nxt = clip_c.empty ? rmfrf_pkg::ST_IDLE : rmfrf_pkg::ST_BASE;
      end
      rmfrf_pkg::ST_BASE: begin
        state_nxt = rmfrf_pkg::ST_RUN;
      end
      rmfrf_pkg::ST_RUN: begin
        if (run_last_col && run_last_row) state_nxt = rmfrf_pkg::ST_DRAIN;
      end
      rmfrf_pkg::ST_DRAIN: begin
        state_nxt = rmfrf_pkg::ST_IDLE;
      end
      rmfrf_pkg::ST_RDWAIT: begin
        if (out_free) state_nxt = rmfrf_pkg::ST_IDLE;
      end
      default: state_nxt = rmfrf_pkg::ST_IDLE;
    endcase
  end

  // Walk counters and RAM port control.
  always_comb begin
    row_base_nxt = row_base_r;
    addr_nxt     = addr_r;
    col_nxt      = col_r;
    rows_nxt     = rows_r;
    wr_pend_nxt  = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = addr_r;
    unique case (state_r)
      rmfrf_pkg::ST_IDLE: begin
        if (in_acc && (in_operation == rmfrf_pkg::OP_READ)) begin
          ram_re    = 1'b1;
          ram_raddr = in_byte_address[AW-1:0];
        end
      end
      rmfrf_pkg::ST_BASE: begin
        row_base_nxt = base_c;
        addr_nxt     = base_c;
        col_nxt      = clip_r.col0;
        rows_nxt     = clip_r.rows;
      end
      rmfrf_pkg::ST_RUN: begin
        ram_re      = 1'b1;
        wr_pend_nxt = 1'b1;
        if (run_last_col) begin
          // Next logical column is the panel row above.
          rows_nxt     = rows_r - rmfrf_pkg::ROW_W'(1);
          col_nxt      = clip_r.col0;
          row_base_nxt = row_base_r - AW'(rmfrf_pkg::ROW_BYTES);
          addr_nxt     = row_base_r - AW'(rmfrf_pkg::ROW_BYTES);
        end else begin
          col_nxt  = col_r + rmfrf_pkg::COL_W'(1);
          addr_nxt = addr_r + AW'(1);
        end
      end
      rmfrf_pkg::ST_CLEAR, rmfrf_pkg::ST_SETUP, rmfrf_pkg::ST_DRAIN,
      rmfrf_pkg::ST_RDWAIT: begin
      end
      default: begin
      end
    endcase
  end

  // Write port: clearing pass, else the modify half of the RMW.
  always_comb begin
    if (state_r == rmfrf_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = rmfrf_pkg::BYTE_WHITE;
    end else begin
      ram_we    = wr_pend_r;
      ram_waddr = wr_addr_r;
      ram_wdata = f_ink_r ? (ram_rdata & ~wr_mask_r) : (ram_rdata | wr_mask_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmfrf_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wr_pend_r <= wr_pend_nxt;
      if (state_r == rmfrf_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    row_base_r <= row_base_nxt;
    addr_r     <= addr_nxt;
    col_r      <= col_nxt;
    rows_r     <= rows_nxt;
    wr_addr_r  <= addr_r;
    wr_mask_r  <= mask_c;
    if (state_r == rmfrf_pkg::ST_SETUP) begin
      clip_r <= clip_c;
    end
    if (in_acc) begin
      f_left_r   <= in_left;
      f_top_r    <= in_top;
      f_span_x_r <= in_span_x;
      f_span_y_r <= in_span_y;
      f_ink_r    <= in_ink_black;
      rd_echo_r  <= in_byte_address;
      rd_oor_r   <= (32'(in_byte_address) >= 32'(rmfrf_pkg::STORE_DEPTH));
    end
    if (load_out) begin
      out_data_r <= rd_oor_r ? '0 : ram_rdata;
      out_addr_r <= rd_echo_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_data_r;
  assign out_read_address = out_addr_r;

endmodule
